// File: design/pdc_pkg.sv
// shared types and constants for the presence hysteresis debounce counter
package pdc_pkg;

  localparam int RANGE_W    = 13;
  localparam int STATUS_W   = 8;
  localparam int DIST_OUT_W = 14;
  localparam int COUNT_OUT_W = 32;
  localparam int THRESH_W   = 13;
  localparam int SAMPLES_W  = 8;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENTER_THRESHOLD = 3'd0,
    CFG_EXIT_THRESHOLD  = 3'd1,
    CFG_ENTER_SAMPLES   = 3'd2,
    CFG_EXIT_SAMPLES    = 3'd3,
    CFG_SENSOR_READY    = 3'd4
  } cfg_index_t;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_CLEAR  = 1'b1
  } kind_t;

  localparam logic [THRESH_W-1:0]  ENTER_THRESHOLD_RST = 13'd1500;
  localparam logic [THRESH_W-1:0]  EXIT_THRESHOLD_RST  = 13'd1800;
  localparam logic [SAMPLES_W-1:0] ENTER_SAMPLES_RST   = 8'd3;
  localparam logic [SAMPLES_W-1:0] EXIT_SAMPLES_RST    = 8'd5;

  typedef struct packed {
    logic                kind;
    logic [RANGE_W-1:0]  range_mm;
    logic [STATUS_W-1:0] range_status;
  } in_item_t;

  typedef struct packed {
    logic signed [DIST_OUT_W-1:0] distance_mm;
    logic                         is_present;
    logic [COUNT_OUT_W-1:0]       arrival_count;
  } out_item_t;

endpackage

// File: design/pdc_stream_if.sv
// valid/ready stream channel with a typed payload
interface pdc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: design/presence_hysteresis_debounce_counter.sv
// presence detector with hysteresis thresholds, debounce streaks and arrival count
//
//  channel     | dir | payload                                  | transfer
//  sample_in   | in  | kind, range_mm, range_status             | valid & ready
//  result_out  | out | distance_mm, is_present, arrival_count    | valid & ready
//  wr_*        | in  | register index and data                  | wr_en
//
// one item per cycle unless the input stalls; state updates in the cycle of the transfer, result registered
// a two-entry output buffer (result register plus skid) keeps input ready while a
// single result waits; input stalls only when both entries are full
// synchronous reset: registers to defaults, streaks and count zero, distance -1
module presence_hysteresis_debounce_counter #(
  parameter int COUNT_WIDTH    = 32,
  parameter int DISTANCE_WIDTH = 13
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [pdc_pkg::CFG_IDX_W-1:0]       wr_index,
  input  logic [pdc_pkg::CFG_DATA_W-1:0]      wr_data,
  pdc_stream_if.sink                          sample_in,
  pdc_stream_if.source                        result_out
);
  import pdc_pkg::*;

  localparam int DLW = DISTANCE_WIDTH + 1;

  logic [THRESH_W-1:0]  enter_threshold_mm;
  logic [THRESH_W-1:0]  exit_threshold_mm;
  logic [SAMPLES_W-1:0] near_needed;
  logic [SAMPLES_W-1:0] far_needed;
  logic                 sensor_ready;

  logic                   present_flag;
  logic [SAMPLES_W-1:0]   near_streak;
  logic [SAMPLES_W-1:0]   far_streak;
  logic [COUNT_WIDTH-1:0] arrivals;
  logic [DLW-1:0]         last_distance;

  logic                   present_flag_next;
  logic [SAMPLES_W-1:0]   near_streak_next;
  logic [SAMPLES_W-1:0]   far_streak_next;
  logic [COUNT_WIDTH-1:0] arrivals_next;
  logic [DLW-1:0]         last_distance_next;

  in_item_t  item;
  out_item_t res;
  logic      accept;

  logic [15:0]               range_ext;
  logic [DISTANCE_WIDTH-1:0] range_val;
  logic [15:0]               dist_cmp;
  logic [SAMPLES_W-1:0]      near_inc;
  logic [SAMPLES_W-1:0]      far_inc;
  logic [16:0]               dist_out_ext;
  logic [63:0]               count_out_ext;

  logic      out_valid;
  out_item_t out_data;
  logic      skid_valid;
  out_item_t skid_data;
  logic      out_free;

  assign item     = sample_in.payload;
  assign sample_in.ready = !skid_valid;
  assign accept   = sample_in.valid && !skid_valid;

  assign range_ext = 16'(item.range_mm);
  assign range_val = range_ext[DISTANCE_WIDTH-1:0];
  assign dist_cmp  = 16'(range_val);
  assign near_inc  = near_streak + 1'b1;
  assign far_inc   = far_streak + 1'b1;

  always_comb begin
    present_flag_next  = present_flag;
    near_streak_next   = near_streak;
    far_streak_next    = far_streak;
    arrivals_next      = arrivals;
    last_distance_next = last_distance;
    if (item.kind == KIND_CLEAR) begin
      arrivals_next = '0;
    end else if (!sensor_ready || item.range_status != '0) begin
      last_distance_next = '1;
    end else begin
      last_distance_next = DLW'(range_val);
      if (dist_cmp < 16'(enter_threshold_mm)) begin
        far_streak_next = '0;
        if (!present_flag) begin
          near_streak_next = near_inc;
          if (near_inc >= near_needed) begin
            present_flag_next = 1'b1;
            near_streak_next  = '0;
            arrivals_next     = arrivals + 1'b1;
          end
        end
      end else if (dist_cmp > 16'(exit_threshold_mm)) begin
        near_streak_next = '0;
        if (present_flag) begin
          far_streak_next = far_inc;
          if (far_inc >= far_needed) begin
            present_flag_next = 1'b0;
            far_streak_next   = '0;
          end
        end
      end
    end
  end

  assign dist_out_ext  = 17'(last_distance_next);
  assign count_out_ext = 64'(arrivals_next);

  always_comb begin
    res.distance_mm   = dist_out_ext[DIST_OUT_W-1:0];
    res.is_present    = present_flag_next;
    res.arrival_count = count_out_ext[COUNT_OUT_W-1:0];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enter_threshold_mm <= ENTER_THRESHOLD_RST;
      exit_threshold_mm  <= EXIT_THRESHOLD_RST;
      near_needed        <= ENTER_SAMPLES_RST;
      far_needed         <= EXIT_SAMPLES_RST;
      sensor_ready       <= 1'b1;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_ENTER_THRESHOLD: enter_threshold_mm <= wr_data[THRESH_W-1:0];
        CFG_EXIT_THRESHOLD:  exit_threshold_mm  <= wr_data[THRESH_W-1:0];
        CFG_ENTER_SAMPLES:   near_needed        <= wr_data[SAMPLES_W-1:0];
        CFG_EXIT_SAMPLES:    far_needed         <= wr_data[SAMPLES_W-1:0];
        CFG_SENSOR_READY:    sensor_ready       <= wr_data[0];
        default: ;
      endcase
    end
  end

  // detector state
  always_ff @(posedge clk) begin
    if (rst) begin
      present_flag  <= 1'b0;
      near_streak   <= '0;
      far_streak    <= '0;
      arrivals      <= '0;
      last_distance <= '1;
    end else if (accept) begin
      present_flag  <= present_flag_next;
      near_streak   <= near_streak_next;
      far_streak    <= far_streak_next;
      arrivals      <= arrivals_next;
      last_distance <= last_distance_next;
    end
  end

  // result register and skid entry
  assign out_free = !out_valid || result_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (accept) begin
        out_data <= res;
      end
    end else if (accept) begin
      skid_data <= res;
    end
  end

  assign result_out.valid   = out_valid;
  assign result_out.payload = out_data;

endmodule

// File: test/tb_presence_hysteresis_debounce_counter.sv
// testbench for the presence hysteresis debounce counter: directed table, then random runs
module tb_presence_hysteresis_debounce_counter;
  timeunit 1ns;
  timeprecision 1ps;

  import pdc_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int RANGE_MAX = (1 << RANGE_W) - 1;

  typedef enum int {
    REGION_NEAR,
    REGION_FAR,
    REGION_DEAD,
    REGION_DROPOUT,
    REGION_CLEAR,
    REGION_NOISE
  } region_t;

  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t given;
  } script_row_t;

  localparam out_item_t BLANK_REPORT = '0;

  localparam script_row_t OPENING [23] = '{
    '{'{KIND_CLEAR, 13'd8191, 8'hFF}, 1'b1, '{14'h3FFF, 1'b0, 32'd0}},
    '{'{KIND_SAMPLE, 13'd0, 8'hFF}, 1'b1, '{14'h3FFF, 1'b0, 32'd0}},
    '{'{KIND_SAMPLE, 13'd8191, 8'h00}, 1'b1, '{14'd8191, 1'b0, 32'd0}},
    '{'{KIND_SAMPLE, 13'd0, 8'h00}, 1'b1, '{14'd0, 1'b0, 32'd0}},
    '{'{KIND_SAMPLE, 13'd1499, 8'h00}, 1'b0, BLANK_REPORT},
    '{'{KIND_SAMPLE, 13'd1650, 8'h00}, 1'b0, BLANK_REPORT},
    '{'{KIND_SAMPLE, 13'd1, 8'h00}, 1'b0, BLANK_REPORT},
    '{'{KIND_SAMPLE, 13'd0, 8'h00}, 1'b0, BLANK_REPORT},
    '{'{KIND_SAMPLE, 13'd1800, 8'h00}, 1'b0, BLANK_REPORT},
    '{'{KIND_SAMPLE, 13'd1801, 8'h00}, 1'b0, BLANK_REPORT},
    '{'{KIND_SAMPLE, 13'd8191, 8'h00}, 1'b0, BLANK_REPORT},
    '{'{KIND_SAMPLE, 13'd100, 8'h00}, 1'b0, BLANK_REPORT},
    '{'{KIND_SAMPLE, 13'd1500, 8'h00}, 1'b0, BLANK_REPORT},
    '{'{KIND_SAMPLE, 13'd4000, 8'h00}, 1'b0, BLANK_REPORT},
    '{'{KIND_SAMPLE, 13'd5000, 8'h00}, 1'b0, BLANK_REPORT},
    '{'{KIND_SAMPLE, 13'd6000, 8'h00}, 1'b0, BLANK_REPORT},
    '{'{KIND_SAMPLE, 13'd7000, 8'h00}, 1'b0, BLANK_REPORT},
    '{'{KIND_SAMPLE, 13'd8191, 8'h00}, 1'b0, BLANK_REPORT},
    '{'{KIND_SAMPLE, 13'd123, 8'h01}, 1'b0, BLANK_REPORT},
    '{'{KIND_CLEAR, 13'd0, 8'h00}, 1'b0, BLANK_REPORT},
    '{'{KIND_SAMPLE, 13'd4096, 8'h80}, 1'b0, BLANK_REPORT},
    '{'{KIND_SAMPLE, 13'd2730, 8'h00}, 1'b0, BLANK_REPORT},
    '{'{KIND_SAMPLE, 13'd5461, 8'h00}, 1'b0, BLANK_REPORT}
  };

  logic                  clk;
  logic                  rst;
  logic                  wr_en;
  cfg_index_t            wr_index;
  logic [CFG_DATA_W-1:0] wr_data;

  pdc_stream_if #(.payload_t(in_item_t))  sample_if ();
  pdc_stream_if #(.payload_t(out_item_t)) result_if ();

  presence_hysteresis_debounce_counter u_dut (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .sample_in  (sample_if),
    .result_out (result_if)
  );

  // predicted block state and registers
  logic [THRESH_W-1:0]   near_limit;
  logic [THRESH_W-1:0]   far_limit;
  logic [SAMPLES_W-1:0]  near_needed;
  logic [SAMPLES_W-1:0]  far_needed;
  logic                  sensor_on;
  logic                  present;
  logic [7:0]            near_run;
  logic [7:0]            far_run;
  logic [31:0]           arrivals;
  logic [DIST_OUT_W-1:0] last_dist;

  out_item_t pending_reports[$];
  int        fail_count;
  bit        calm;

  function automatic out_item_t track_presence(input in_item_t it);
    out_item_t r;
    if (it.kind == KIND_CLEAR) begin
      arrivals = '0;
    end else if (!sensor_on || it.range_status != '0) begin
      last_dist = '1;
    end else begin
      last_dist = {1'b0, it.range_mm};
      if (it.range_mm < near_limit) begin
        far_run = '0;
        if (!present) begin
          near_run = near_run + 8'd1;
          if (near_run >= near_needed) begin
            present = 1'b1;
            near_run = '0;
            arrivals = arrivals + 32'd1;
          end
        end
      end else if (it.range_mm > far_limit) begin
        near_run = '0;
        if (present) begin
          far_run = far_run + 8'd1;
          if (far_run >= far_needed) begin
            present = 1'b0;
            far_run = '0;
          end
        end
      end
    end
    r.distance_mm = last_dist;
    r.is_present = present;
    r.arrival_count = arrivals;
    return r;
  endfunction

  function automatic logic [RANGE_W-1:0] pick_range(input region_t region);
    case (region)
      REGION_NEAR: begin
        if (near_limit != '0) return RANGE_W'($urandom_range(int'(near_limit) - 1, 0));
      end
      REGION_FAR: begin
        if (far_limit != RANGE_MAX) begin
          return RANGE_W'($urandom_range(RANGE_MAX, int'(far_limit) + 1));
        end
      end
      REGION_DEAD: begin
        if (near_limit <= far_limit) begin
          return RANGE_W'($urandom_range(int'(far_limit), int'(near_limit)));
        end
      end
      default: ;
    endcase
    return RANGE_W'($urandom);
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t given);
    out_item_t predicted;
    while (!calm && $urandom_range(99) < 27) begin
      sample_if.valid <= 1'b0;
      @(negedge clk);
    end
    sample_if.valid <= 1'b1;
    sample_if.payload <= it;
    do @(posedge clk); while (!sample_if.ready);
    predicted = track_presence(it);
    pending_reports.push_back(typed ? given : predicted);
    @(negedge clk);
  endtask

  task automatic settle();
    sample_if.valid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic apply_setting(input logic [THRESH_W-1:0] thr_in,
                               input logic [THRESH_W-1:0] thr_out,
                               input logic [SAMPLES_W-1:0] n_in,
                               input logic [SAMPLES_W-1:0] n_out,
                               input logic on);
    logic [CFG_DATA_W-1:0] values [5];
    cfg_index_t            idx;
    settle();
    values = '{thr_in, thr_out, CFG_DATA_W'(n_in), CFG_DATA_W'(n_out), CFG_DATA_W'(on)};
    for (int i = 0; i < 5; i++) begin
      idx = cfg_index_t'(i);
      wr_en <= 1'b1;
      wr_index <= idx;
      wr_data <= values[i];
      @(posedge clk);
      case (idx)
        CFG_ENTER_THRESHOLD: near_limit = values[i][THRESH_W-1:0];
        CFG_EXIT_THRESHOLD:  far_limit = values[i][THRESH_W-1:0];
        CFG_ENTER_SAMPLES:   near_needed = values[i][SAMPLES_W-1:0];
        CFG_EXIT_SAMPLES:    far_needed = values[i][SAMPLES_W-1:0];
        CFG_SENSOR_READY:    sensor_on = values[i][0];
        default: ;
      endcase
      @(negedge clk);
    end
    wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // runs of near or far samples sized around the streak counts, mixed with dead-band, dropout, clear and noise items
  task automatic feed_traffic(input int quota);
    int       sent;
    int       run_len;
    int       pick;
    int       needed;
    region_t  region;
    in_item_t it;
    sent = 0;
    while (sent < quota) begin
      pick = $urandom_range(99);
      if (pick < 38) region = REGION_NEAR;
      else if (pick < 74) region = REGION_FAR;
      else if (pick < 84) region = REGION_DEAD;
      else if (pick < 92) region = REGION_DROPOUT;
      else if (pick < 96) region = REGION_CLEAR;
      else region = REGION_NOISE;
      if (region == REGION_NEAR || region == REGION_FAR) begin
        needed = (region == REGION_NEAR) ? int'(near_needed) : int'(far_needed);
        if (needed == 0) needed = 1;
        if ($urandom_range(1)) run_len = needed + $urandom_range(2);
        else run_len = $urandom_range(needed, 1);
      end else begin
        run_len = $urandom_range(3, 1);
      end
      for (int i = 0; i < run_len; i++) begin
        it.kind = KIND_SAMPLE;
        it.range_mm = pick_range(region);
        it.range_status = '0;
        case (region)
          REGION_DROPOUT: it.range_status = STATUS_W'($urandom_range(255, 1));
          REGION_CLEAR: begin
            it.kind = KIND_CLEAR;
            it.range_status = STATUS_W'($urandom);
          end
          REGION_NOISE: begin
            it.kind = kind_t'($urandom_range(1));
            it.range_status = $urandom_range(1) ? '0 : STATUS_W'($urandom);
          end
          default: ;
        endcase
        send_item(it, 1'b0, BLANK_REPORT);
        sent++;
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(negedge clk) begin
    result_if.ready <= calm || ($urandom_range(99) >= 27);
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      if (pending_reports.size() == 0) begin
        $error("result transfer with nothing expected");
        fail_count++;
      end else begin
        want = pending_reports.pop_front();
        if (result_if.payload.distance_mm !== want.distance_mm) begin
          $error("distance_mm: expected %0d, got %0d",
                 $signed(want.distance_mm), $signed(result_if.payload.distance_mm));
          fail_count++;
        end
        if (result_if.payload.is_present !== want.is_present) begin
          $error("is_present: expected %0d, got %0d",
                 want.is_present, result_if.payload.is_present);
          fail_count++;
        end
        if (result_if.payload.arrival_count !== want.arrival_count) begin
          $error("arrival_count: expected %0d, got %0d",
                 want.arrival_count, result_if.payload.arrival_count);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (sample_if.valid && sample_if.ready) ||
          (result_if.valid && result_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = CFG_ENTER_THRESHOLD;
    wr_data = '0;
    sample_if.valid = 1'b0;
    sample_if.payload = '0;
    calm = 1'b0;
    near_limit = ENTER_THRESHOLD_RST;
    far_limit = EXIT_THRESHOLD_RST;
    near_needed = ENTER_SAMPLES_RST;
    far_needed = EXIT_SAMPLES_RST;
    sensor_on = 1'b1;
    present = 1'b0;
    near_run = '0;
    far_run = '0;
    arrivals = '0;
    last_dist = '1;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (OPENING[i]) begin
      send_item(OPENING[i].item, OPENING[i].typed, OPENING[i].given);
    end

    apply_setting(13'd1500, 13'd1800, 8'd3, 8'd5, 1'b1);
    feed_traffic(200);
    apply_setting(13'd0, 13'd8191, 8'd1, 8'd1, 1'b1);
    feed_traffic(50);
    // crossed thresholds, near test wins
    apply_setting(13'd8191, 13'd0, 8'd2, 8'd2, 1'b1);
    feed_traffic(120);
    // zero counts act like one, with no idling on either side
    calm = 1'b1;
    apply_setting(13'd4000, 13'd4100, 8'd0, 8'd0, 1'b1);
    feed_traffic(120);
    calm = 1'b0;
    apply_setting(13'd2000, 13'd2500, 8'd2, 8'd2, 1'b0);
    feed_traffic(40);
    apply_setting(13'd2000, 13'd2500, 8'd255, 8'd255, 1'b1);
    feed_traffic(550);
    apply_setting(THRESH_W'($urandom), THRESH_W'($urandom),
                  SAMPLES_W'($urandom_range(8, 1)), SAMPLES_W'($urandom_range(8, 1)), 1'b1);
    feed_traffic(100);

    settle();
    repeat (5) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
